/* rtl/spq_pkg.sv */
// Shared types and constants for the stable priority queue.
// No dependencies; every other file of the block uses this package.
`default_nettype none

package spq_pkg;

  localparam int CAPACITY  = 16;
  localparam int PRIO_W    = 8;
  localparam int VALUE_W   = 32;
  localparam int FILL_W    = 5;

  typedef logic [PRIO_W-1:0]         prio_t;
  typedef logic signed [VALUE_W-1:0] value_t;
  typedef logic [FILL_W-1:0]         fill_t;

  // Transaction kind on the request channel
  typedef enum logic {
    MODE_PUT = 1'b0,
    MODE_GET = 1'b1
  } mode_t;

  // Response status codes
  typedef enum logic [1:0] {
    STAT_PUT_DONE  = 2'd0,
    STAT_GET_DONE  = 2'd1,
    STAT_GET_EMPTY = 2'd2,
    STAT_PUT_FULL  = 2'd3
  } status_t;

  // Datapath operation issued by the controller
  typedef enum logic [2:0] {
    OP_NONE,
    OP_PUT,
    OP_GET,
    OP_PUT_FULL,
    OP_GET_EMPTY
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RESP
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;  // capture request payload
    op_t  op;    // operation to apply to the store and the response register
  } spq_cmd_t;

  // Datapath to controller
  typedef struct packed {
    mode_t mode;   // latched request kind
    logic  empty;
    logic  full;
  } spq_stat_t;

endpackage

`default_nettype wire

/* rtl/spq_req_if.sv */
// Request channel of the stable priority queue: valid/ready plus payload.
// Depends on spq_pkg for payload types.
`default_nettype none

interface spq_req_if;
  logic                valid;
  logic                ready;
  spq_pkg::mode_t      mode;
  spq_pkg::prio_t      priority_req;
  spq_pkg::value_t     value;

  modport source (output valid, output mode, output priority_req, output value,
                  input ready);
  modport sink   (input valid, input mode, input priority_req, input value,
                  output ready);
endinterface

`default_nettype wire

/* rtl/spq_rsp_if.sv */
// Response channel of the stable priority queue: valid/ready plus payload.
// Depends on spq_pkg for payload types.
`default_nettype none

interface spq_rsp_if;
  logic                valid;
  logic                ready;
  spq_pkg::status_t    status;
  spq_pkg::prio_t      out_priority;
  spq_pkg::value_t     out_value;
  spq_pkg::fill_t      fill;

  modport source (output valid, output status, output out_priority, output out_value,
                  output fill, input ready);
  modport sink   (input valid, input status, input out_priority, input out_value,
                  input fill, output ready);
endinterface

`default_nettype wire

/* rtl/spq_ctrl.sv */
// Controller of the stable priority queue: handshakes and operation select.
// Depends on spq_pkg.
`default_nettype none

module spq_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               req_valid,
  output logic                    req_ready,
  output logic                    rsp_valid,
  input  wire logic               rsp_ready,
  input  wire spq_pkg::spq_stat_t stat,
  output spq_pkg::spq_cmd_t       cmd
);
  import spq_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req_valid) state_next = ST_EXEC;
      end
      ST_EXEC: state_next = ST_RESP;
      ST_RESP: begin
        if (rsp_ready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    req_ready = 1'b0;
    rsp_valid = 1'b0;
    cmd.load  = 1'b0;
    cmd.op    = OP_NONE;
    case (state)
      ST_IDLE: begin
        req_ready = 1'b1;
        cmd.load  = req_valid;
      end
      ST_EXEC: begin
        // pick the operation from the latched kind and the store's status
        if (stat.mode == MODE_PUT) begin
          cmd.op = stat.full ? OP_PUT_FULL : OP_PUT;
        end else begin
          cmd.op = stat.empty ? OP_GET_EMPTY : OP_GET;
        end
      end
      ST_RESP: rsp_valid = 1'b1;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

/* rtl/spq_dpath.sv */
// Datapath of the stable priority queue: request latch, sorted cell row,
// occupancy count and response register. Depends on spq_pkg.
`default_nettype none

module spq_dpath (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire spq_pkg::spq_cmd_t cmd,
  output spq_pkg::spq_stat_t     stat,
  input  wire spq_pkg::mode_t    mode,
  input  wire spq_pkg::prio_t    priority_req,
  input  wire spq_pkg::value_t   value,
  output spq_pkg::status_t       status,
  output spq_pkg::prio_t         out_priority,
  output spq_pkg::value_t        out_value,
  output spq_pkg::fill_t         fill
);
  import spq_pkg::*;

  mode_t  req_mode;
  prio_t  req_prio;
  value_t req_val;

  prio_t  cell_prio [CAPACITY];
  value_t cell_val  [CAPACITY];
  prio_t  cell_prio_next [CAPACITY];
  value_t cell_val_next  [CAPACITY];
  logic [CAPACITY-1:0] ge;   // cell holds an entry at or above the new priority

  fill_t  occupancy;
  fill_t  occupancy_next;

  // Latch request payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_mode <= mode;
      req_prio <= priority_req;
      req_val  <= value;
    end
  end

  assign stat.mode  = req_mode;
  assign stat.empty = (occupancy == '0);
  assign stat.full  = (occupancy == FILL_W'(CAPACITY));

  // Per-cell compare; the row is sorted so ge is a prefix of valid cells
  always_comb begin
    for (int k = 0; k < CAPACITY; k++) begin
      ge[k] = (FILL_W'(k) < occupancy) && (cell_prio[k] >= req_prio);
    end
  end

  // Per-cell next value: hold, take the new entry, or shift
  always_comb begin
    for (int k = 0; k < CAPACITY; k++) begin
      cell_prio_next[k] = cell_prio[k];
      cell_val_next[k]  = cell_val[k];
    end
    occupancy_next = occupancy;
    case (cmd.op)
      OP_PUT: begin
        if (!ge[0]) begin
          cell_prio_next[0] = req_prio;
          cell_val_next[0]  = req_val;
        end
        for (int k = 1; k < CAPACITY; k++) begin
          if (!ge[k]) begin
            if (ge[k-1]) begin
              cell_prio_next[k] = req_prio;
              cell_val_next[k]  = req_val;
            end else begin
              cell_prio_next[k] = cell_prio[k-1];
              cell_val_next[k]  = cell_val[k-1];
            end
          end
        end
        occupancy_next = occupancy + fill_t'(1);
      end
      OP_GET: begin
        for (int k = 0; k < CAPACITY - 1; k++) begin
          cell_prio_next[k] = cell_prio[k+1];
          cell_val_next[k]  = cell_val[k+1];
        end
        occupancy_next = occupancy - fill_t'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < CAPACITY; k++) begin
      cell_prio[k] <= cell_prio_next[k];
      cell_val[k]  <= cell_val_next[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occupancy <= '0;
    end else begin
      occupancy <= occupancy_next;
    end
  end

  // Response register, loaded when the operation executes
  always_ff @(posedge clk) begin
    if (cmd.op != OP_NONE) begin
      out_priority <= '0;
      out_value    <= '0;
      fill         <= occupancy_next;
      case (cmd.op)
        OP_PUT:       status <= STAT_PUT_DONE;
        OP_PUT_FULL:  status <= STAT_PUT_FULL;
        OP_GET_EMPTY: status <= STAT_GET_EMPTY;
        OP_GET: begin
          status       <= STAT_GET_DONE;
          out_priority <= cell_prio[0];
          out_value    <= cell_val[0];
        end
        default:      status <= STAT_PUT_DONE;
      endcase
    end
  end

endmodule

`default_nettype wire

/* rtl/stable_priority_queue_top.sv */
// Top level of the stable priority queue: controller plus datapath.
// Depends on spq_pkg, spq_req_if, spq_rsp_if, spq_ctrl and spq_dpath.
`default_nettype none

// Stable priority queue of CAPACITY (16) entries, each an 8-bit priority and
// a 32-bit signed value, kept sorted in a row of registers with the front
// entry in cell zero. A put (mode 0) lands behind every stored entry of equal
// or higher priority, so higher priorities leave first and equal priorities
// leave in arrival order; a put into a full store is dropped with status 3.
// A get (mode 1) removes and returns the front entry, or reports status 2 on
// an empty store. Every request transaction yields exactly one response
// transaction carrying the status, the removed entry (zero unless a get
// succeeded) and the fill level after the operation. Each cell compares its
// priority with the new one and shifts in parallel, so the whole row is updated
// at once. Sequence: a request is taken in the idle state, applied to the cell
// row on the next cycle, and its response is offered on the cycle after that,
// held until taken; the next request is taken the cycle after the response
// leaves. Nothing needs clearing after reset: only occupied cells are ever
// read.
module stable_priority_queue_top (
  input wire logic clk,
  input wire logic rst,
  spq_req_if.sink  req,
  spq_rsp_if.source rsp
);
  import spq_pkg::*;

  spq_cmd_t  cmd;
  spq_stat_t stat;

  // Sequence handshakes and choose the operation
  spq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Hold the sorted entries and build the response
  spq_dpath u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .mode         (req.mode),
    .priority_req (req.priority_req),
    .value        (req.value),
    .status       (rsp.status),
    .out_priority (rsp.out_priority),
    .out_value    (rsp.out_value),
    .fill         (rsp.fill)
  );

endmodule

`default_nettype wire

/* bench/tb_stable_priority_queue_top.sv */
// Self-checking testbench for stable_priority_queue_top: directed and random
// put/get traffic, each response checked against a shadow of the sorted store.
// Depends on spq_pkg, spq_req_if, spq_rsp_if and the block's RTL.

module tb_stable_priority_queue_top;
  timeunit 1ns;
  timeprecision 1ps;

  import spq_pkg::*;

  // Hard stop: roughly 5x the slowest legal run (about 2k transactions, each
  // with the longest sender gap, the longest receiver stall and the time the
  // block itself takes).
  localparam int unsigned RUN_LIMIT_NS = 5_000_000;
  // Cycles to linger after the last response.
  localparam int unsigned TAIL_CYCLES  = 12;
  localparam int unsigned MAX_REPORTS  = 10;

  // One response as the block should present it.
  typedef struct {
    status_t status;
    prio_t   prio;
    value_t  val;
    fill_t   fill;
  } queue_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  spq_req_if req_ch ();
  spq_rsp_if rsp_ch ();

  stable_priority_queue_top u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Shadow of the sorted store: slot 0 is the front entry.
  prio_t  shadow_prio [CAPACITY];
  value_t shadow_val  [CAPACITY];
  int     shadow_count = 0;

  // Responses still owed by the block, oldest first.
  queue_result_t pending_results [$];

  int unsigned mismatch_count = 0;
  bit          no_gaps = 1'b0;  // set to run both sides back to back

  // Idle length: mostly none or short, now and then long.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (no_gaps || roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 20);
  endfunction

  // Apply one request to the shadow store and return the response it owes.
  function automatic queue_result_t apply_to_shadow(mode_t m, prio_t p, value_t v);
    queue_result_t r;
    int pos;
    r.prio = '0;
    r.val  = '0;
    if (m == MODE_PUT) begin
      if (shadow_count >= CAPACITY) begin
        r.status = STAT_PUT_FULL;
      end else begin
        // Land behind every entry of equal or higher priority.
        pos = 0;
        while (pos < shadow_count && shadow_prio[pos] >= p) pos++;
        for (int k = shadow_count; k > pos; k--) begin
          shadow_prio[k] = shadow_prio[k-1];
          shadow_val[k]  = shadow_val[k-1];
        end
        shadow_prio[pos] = p;
        shadow_val[pos]  = v;
        shadow_count++;
        r.status = STAT_PUT_DONE;
      end
    end else begin
      if (shadow_count == 0) begin
        r.status = STAT_GET_EMPTY;
      end else begin
        r.prio = shadow_prio[0];
        r.val  = shadow_val[0];
        for (int k = 1; k < shadow_count; k++) begin
          shadow_prio[k-1] = shadow_prio[k];
          shadow_val[k-1]  = shadow_val[k];
        end
        shadow_count--;
        r.status = STAT_GET_DONE;
      end
    end
    r.fill = fill_t'(shadow_count);
    return r;
  endfunction

  // Offer one request after a random gap and hold it until the block takes
  // it. Valid stays high on return so that a gapless follow-up needs only a
  // single assignment in its step.
  task automatic send_request(mode_t m, prio_t p, value_t v);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid        <= 1'b1;
    req_ch.mode         <= m;
    req_ch.priority_req <= p;
    req_ch.value        <= v;
    do @(posedge clk); while (!req_ch.ready);
    // Accepted at this edge: record what the block owes for it.
    pending_results.push_back(apply_to_shadow(m, p, v));
  endtask

  // Drop valid and hold off until every owed response has come back.
  task automatic wait_for_idle();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Priority with a bias: full range, a narrow band for ties, or the ends.
  function automatic prio_t pick_priority(int unsigned style, prio_t band_base);
    case (style)
      0: return prio_t'($urandom);
      1: return band_base + prio_t'($urandom_range(0, 3));
      default: return $urandom_range(0, 1) ? '1 : '0;
    endcase
  endfunction

  // ---------------------------------------------------------------- tests

  // A get on a freshly reset store must report empty with zero payload.
  task automatic test_empty_get();
    send_request(MODE_GET, 8'hA5, 32'sh5A5A_5A5A);
  endtask

  // Extreme priorities and values, with two ties: equal priorities must
  // leave in arrival order. Drain fully, then one more get on empty.
  task automatic test_order_and_ties();
    send_request(MODE_PUT, '0, 32'sh8000_0000);
    send_request(MODE_PUT, '1, 32'sh7FFF_FFFF);
    send_request(MODE_PUT, '1, -32'sd1);
    send_request(MODE_PUT, '0, 32'sd0);
    repeat (5) send_request(MODE_GET, '0, 32'sd0);
  endtask

  // Fill the store to capacity with mixed and tied priorities, then push
  // one more with the top priority: it must be dropped and flagged full.
  task automatic test_full_store();
    prio_t p;
    for (int i = 0; i < CAPACITY; i++) begin
      case (i % 3)
        0: p = '1;
        1: p = '0;
        default: p = prio_t'(i * 16);
      endcase
      send_request(MODE_PUT, p, value_t'(i[0] ? 32'hAAAA_AAAA : 32'h5555_5555) + i);
    end
    send_request(MODE_PUT, '1, 32'sh1234_5678);
  endtask

  // Phases that alternate between fill-heavy and drain-heavy mixes so the
  // store swings between full and empty, with a balanced phase in between.
  // Some phases run with no idling on either side; in one, the sender pauses
  // until the block has answered everything.
  task automatic test_random_traffic();
    int unsigned put_pct;
    int unsigned style;
    int unsigned count;
    prio_t       band_base;
    mode_t       m;
    for (int phase = 0; phase < 12; phase++) begin
      no_gaps   = (phase % 4 == 3);
      put_pct   = (phase % 3 == 2) ? 50 :
                  (phase % 2 == 1) ? $urandom_range(10, 25) : $urandom_range(75, 95);
      style     = $urandom_range(0, 2);
      band_base = prio_t'($urandom);
      count     = $urandom_range(130, 190);
      repeat (count) begin
        m = ($urandom_range(0, 99) < put_pct) ? MODE_PUT : MODE_GET;
        send_request(m, pick_priority(style, band_base), value_t'($urandom));
      end
      if (phase == 5) wait_for_idle();
    end
    no_gaps = 1'b0;
  endtask

  // ------------------------------------------------------- response side

  // Receiver: ready in runs, broken by stalls of random length.
  initial begin
    int unsigned run_len;
    int unsigned stall;
    rsp_ch.ready = 1'b0;
    forever begin
      run_len = $urandom_range(1, 8);
      rsp_ch.ready <= 1'b1;
      repeat (run_len) @(posedge clk);
      stall = pick_gap();
      if (stall > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  // Compare every accepted response against the oldest owed one.
  always @(posedge clk) begin
    queue_result_t want;
    bit bad;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("%0t: response with none owed: status=%s prio=%0d value=%0d fill=%0d",
                   $realtime, rsp_ch.status.name(), rsp_ch.out_priority,
                   rsp_ch.out_value, rsp_ch.fill);
      end else begin
        want = pending_results.pop_front();
        bad  = 1'b0;
        if (rsp_ch.status       !== want.status) bad = 1'b1;
        if (rsp_ch.out_priority !== want.prio)   bad = 1'b1;
        if (rsp_ch.out_value    !== want.val)    bad = 1'b1;
        if (rsp_ch.fill         !== want.fill)   bad = 1'b1;
        if (bad) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display({"%0t: mismatch: expected status=%s prio=%0d value=%0d fill=%0d,",
                      " got status=%s prio=%0d value=%0d fill=%0d"},
                     $realtime, want.status.name(), want.prio, want.val, want.fill,
                     rsp_ch.status.name(), rsp_ch.out_priority, rsp_ch.out_value,
                     rsp_ch.fill);
        end
      end
    end
  end

  // ------------------------------------------------------------ sequence

  initial begin
    req_ch.valid        = 1'b0;
    req_ch.mode         = MODE_PUT;
    req_ch.priority_req = '0;
    req_ch.value        = '0;

    // Hold reset, then release it before the first test.
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_get();
    test_order_and_ties();
    test_full_store();
    test_random_traffic();

    // Drain, then let the block settle before the verdict.
    wait_for_idle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("tb_stable_priority_queue_top passed");
    end else begin
      $display("tb_stable_priority_queue_top failed");
    end
    $finish;
  end

  // Stop a hung run.
  initial begin
    #(RUN_LIMIT_NS);
    $display("tb_stable_priority_queue_top failed");
    $finish;
  end

endmodule
